// ===== hw/rtl/zoll_pkg.sv =====
// Package for the z-order layer list: sizes, the hidden-height code and the
// controller state type. No dependencies.
package zoll_pkg;

  localparam int NUM_SHEETS = 256;
  localparam int SHEET_AW   = $clog2(NUM_SHEETS);
  localparam int ID_W       = 8;
  localparam int HEIGHT_W   = 9;

  // Height code of a hidden sheet (-1).
  localparam logic signed [HEIGHT_W-1:0] HEIGHT_HIDDEN = '1;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_LOOKUP = 5'b00010,
    ST_SHIFT  = 5'b00100,
    ST_FINAL  = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

endpackage

// ===== hw/rtl/zoll_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module zoll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/z_order_layer_list_top.sv =====
// Z-order layer list: layer order table and per-sheet height table in two
// RAMs, with a controller that shifts order entries one per cycle.
// Depends on zoll_pkg and zoll_ram.
//
//   Channel | Direction | Handshake          | Payload
//   in_     | input     | in_valid/in_stall  | sheet_id, target_height
//   out_    | output    | out_valid/out_stall| applied_height, refresh, map_from_layer,
//           |           |                    | draw_from_layer, draw_to_layer, top_layer
//
// The order RAM, with its one read and one write per cycle, moves the order entries
// of an item (0 to NUM_SHEETS-1 of them) one after another; an item that changes
// nothing moves none. A stalled output register holds the controller in ST_DONE.
// A result waits in an output register, so the next item is taken meanwhile.
// Reset marks every sheet hidden at once through per-sheet valid bits; the
// order table needs no clearing.

module z_order_layer_list_top
  import zoll_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [ID_W-1:0]            in_sheet_id,
  input  logic signed [HEIGHT_W-1:0] in_target_height,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [HEIGHT_W-1:0] out_applied_height,
  output logic                       out_refresh,
  output logic [HEIGHT_W-1:0]        out_map_from_layer,
  output logic [HEIGHT_W-1:0]        out_draw_from_layer,
  output logic signed [HEIGHT_W-1:0] out_draw_to_layer,
  output logic signed [HEIGHT_W-1:0] out_top_layer
);

  state_t state_r, state_nxt;

  logic [ID_W-1:0]            id_r, id_nxt;
  logic signed [HEIGHT_W-1:0] req_r, req_nxt;
  logic signed [HEIGHT_W-1:0] top_r, top_nxt;
  logic signed [HEIGHT_W-1:0] h_r, h_nxt;
  logic                       hide_r, hide_nxt;
  logic                       up_r, up_nxt;
  logic [HEIGHT_W-1:0]        src_r, src_nxt;
  logic [HEIGHT_W-1:0]        wdst_r, wdst_nxt;
  logic [HEIGHT_W-1:0]        rem_r, rem_nxt;
  logic                       pend_r, pend_nxt;
  logic [NUM_SHEETS-1:0]      hvalid_r;

  logic                       res_refresh_r, res_refresh_nxt;
  logic [HEIGHT_W-1:0]        res_map_r, res_map_nxt;
  logic [HEIGHT_W-1:0]        res_from_r, res_from_nxt;
  logic signed [HEIGHT_W-1:0] res_to_r, res_to_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic signed [HEIGHT_W-1:0] out_applied_r;
  logic                       out_refresh_r;
  logic [HEIGHT_W-1:0]        out_map_r;
  logic [HEIGHT_W-1:0]        out_from_r;
  logic signed [HEIGHT_W-1:0] out_to_r;
  logic signed [HEIGHT_W-1:0] out_top_r;
  logic                       out_load;

  // RAM ports.
  logic                  ord_we;
  logic [SHEET_AW-1:0]   ord_waddr, ord_raddr;
  logic [ID_W-1:0]       ord_wdata, ord_rdata;
  logic                  hs_we;
  logic [SHEET_AW-1:0]   hs_waddr, hs_raddr;
  logic [HEIGHT_W-1:0]   hs_wdata, hs_rdata;

  // Lookup arithmetic, one bit wider than the stored heights.
  logic signed [HEIGHT_W:0] old_w, top_w, lim_w, req_w, h_w;
  logic                     id_ok;

  zoll_ram #(.WIDTH(ID_W), .DEPTH(NUM_SHEETS)) u_order_ram (
    .clk   (clk),
    .we    (ord_we),
    .waddr (ord_waddr),
    .wdata (ord_wdata),
    .raddr (ord_raddr),
    .rdata (ord_rdata)
  );

  zoll_ram #(.WIDTH(HEIGHT_W), .DEPTH(NUM_SHEETS)) u_height_ram (
    .clk   (clk),
    .we    (hs_we),
    .waddr (hs_waddr),
    .wdata (hs_wdata),
    .raddr (hs_raddr),
    .rdata (hs_rdata)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    id_ok = ({1'b0, id_r} < HEIGHT_W'(NUM_SHEETS));
    old_w = hvalid_r[id_r[SHEET_AW-1:0]] ? {hs_rdata[HEIGHT_W-1], hs_rdata}
                                         : {(HEIGHT_W+1){1'b1}};
    top_w = {top_r[HEIGHT_W-1], top_r};
    req_w = {req_r[HEIGHT_W-1], req_r};
    lim_w = (old_w >= 0) ? top_w : top_w + 2'sd1;
    h_w   = (req_w > lim_w) ? lim_w : req_w;
    if (h_w < -1) begin
      h_w = '1;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    id_nxt          = id_r;
    req_nxt         = req_r;
    top_nxt         = top_r;
    h_nxt           = h_r;
    hide_nxt        = hide_r;
    up_nxt          = up_r;
    src_nxt         = src_r;
    wdst_nxt        = wdst_r;
    rem_nxt         = rem_r;
    pend_nxt        = pend_r;
    res_refresh_nxt = res_refresh_r;
    res_map_nxt     = res_map_r;
    res_from_nxt    = res_from_r;
    res_to_nxt      = res_to_r;

    ord_we    = 1'b0;
    ord_waddr = wdst_r[SHEET_AW-1:0];
    ord_wdata = ord_rdata;
    ord_raddr = src_r[SHEET_AW-1:0];
    hs_we     = 1'b0;
    hs_waddr  = ord_rdata[SHEET_AW-1:0];
    hs_wdata  = wdst_r;
    hs_raddr  = in_sheet_id[SHEET_AW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          id_nxt    = in_sheet_id;
          req_nxt   = in_target_height;
          state_nxt = ST_LOOKUP;
        end
      end

      ST_LOOKUP: begin
        pend_nxt        = 1'b0;
        hide_nxt        = 1'b0;
        h_nxt           = h_w[HEIGHT_W-1:0];
        res_refresh_nxt = 1'b0;
        res_map_nxt     = '0;
        res_from_nxt    = '0;
        res_to_nxt      = HEIGHT_HIDDEN;
        state_nxt       = ST_DONE;
        if (!id_ok) begin
          h_nxt = HEIGHT_HIDDEN;
        end else if (old_w > h_w) begin
          res_refresh_nxt = 1'b1;
          state_nxt       = ST_SHIFT;
          if (h_w >= 0) begin
            // Lower: entries between move up by one.
            up_nxt       = 1'b0;
            src_nxt      = HEIGHT_W'(old_w - 2'sd1);
            rem_nxt      = HEIGHT_W'(old_w - h_w);
            res_map_nxt  = HEIGHT_W'(h_w + 2'sd1);
            res_from_nxt = HEIGHT_W'(h_w + 2'sd1);
            res_to_nxt   = old_w[HEIGHT_W-1:0];
          end else begin
            // Hide: entries above move down and the stack shrinks.
            hide_nxt   = 1'b1;
            up_nxt     = 1'b1;
            src_nxt    = HEIGHT_W'(old_w + 2'sd1);
            rem_nxt    = HEIGHT_W'(top_w - old_w);
            top_nxt    = HEIGHT_W'(top_w - 2'sd1);
            res_to_nxt = HEIGHT_W'(old_w - 2'sd1);
          end
        end else if (old_w < h_w) begin
          res_refresh_nxt = 1'b1;
          state_nxt       = ST_SHIFT;
          res_map_nxt     = h_w[HEIGHT_W-1:0];
          res_from_nxt    = h_w[HEIGHT_W-1:0];
          res_to_nxt      = h_w[HEIGHT_W-1:0];
          if (old_w >= 0) begin
            // Raise: entries between move down by one.
            up_nxt  = 1'b1;
            src_nxt = HEIGHT_W'(old_w + 2'sd1);
            rem_nxt = HEIGHT_W'(h_w - old_w);
          end else begin
            // Insert: entries at the target and above move up.
            up_nxt  = 1'b0;
            src_nxt = top_w[HEIGHT_W-1:0];
            rem_nxt = HEIGHT_W'(top_w - h_w + 2'sd1);
            top_nxt = HEIGHT_W'(top_w + 2'sd1);
          end
        end
      end

      ST_SHIFT: begin
        // Reads run one entry ahead of writes; a read never hits an entry
        // that has already been rewritten in this pass.
        if (rem_r != '0) begin
          src_nxt  = up_r ? src_r + 1'b1 : src_r - 1'b1;
          wdst_nxt = up_r ? src_r - 1'b1 : src_r + 1'b1;
          rem_nxt  = rem_r - 1'b1;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          ord_we = 1'b1;
          hs_we  = 1'b1;
        end
        if (rem_r == '0 && !pend_r) begin
          state_nxt = ST_FINAL;
        end
      end

      ST_FINAL: begin
        hs_we    = 1'b1;
        hs_waddr = id_r[SHEET_AW-1:0];
        if (hide_r) begin
          hs_wdata = HEIGHT_HIDDEN;
        end else begin
          hs_wdata  = h_r;
          ord_we    = 1'b1;
          ord_waddr = h_r[SHEET_AW-1:0];
          ord_wdata = id_r;
        end
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      top_r       <= HEIGHT_HIDDEN;
      pend_r      <= 1'b0;
      hvalid_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (hs_we) begin
        hvalid_r[hs_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    id_r          <= id_nxt;
    req_r         <= req_nxt;
    h_r           <= h_nxt;
    hide_r        <= hide_nxt;
    up_r          <= up_nxt;
    src_r         <= src_nxt;
    wdst_r        <= wdst_nxt;
    rem_r         <= rem_nxt;
    res_refresh_r <= res_refresh_nxt;
    res_map_r     <= res_map_nxt;
    res_from_r    <= res_from_nxt;
    res_to_r      <= res_to_nxt;
    if (out_load) begin
      out_applied_r <= h_r;
      out_refresh_r <= res_refresh_r;
      out_map_r     <= res_map_r;
      out_from_r    <= res_from_r;
      out_to_r      <= res_to_r;
      out_top_r     <= top_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_applied_height  = out_applied_r;
  assign out_refresh         = out_refresh_r;
  assign out_map_from_layer  = out_map_r;
  assign out_draw_from_layer = out_from_r;
  assign out_draw_to_layer   = out_to_r;
  assign out_top_layer       = out_top_r;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for z_order_layer_list_top: a clocked driver and monitor
// around the block, with its own model of the layer stack that predicts every result.
// Depends on zoll_pkg and the block's RTL.
module testbench
  import zoll_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HIDDEN      = -1;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int PHASE_ITEMS = 200;
  localparam int SETTLE      = NUM_SHEETS + 40;

  typedef struct packed {
    logic [ID_W-1:0]            sheet;
    logic signed [HEIGHT_W-1:0] target;
  } restack_req_t;

  typedef struct packed {
    logic signed [HEIGHT_W-1:0] applied;
    logic                       refresh;
    logic [HEIGHT_W-1:0]        map_from;
    logic [HEIGHT_W-1:0]        draw_from;
    logic signed [HEIGHT_W-1:0] draw_to;
    logic signed [HEIGHT_W-1:0] top;
  } redraw_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [ID_W-1:0]            in_sheet_id = '0;
  logic signed [HEIGHT_W-1:0] in_target_height = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [HEIGHT_W-1:0] out_applied_height;
  logic                       out_refresh;
  logic [HEIGHT_W-1:0]        out_map_from_layer;
  logic [HEIGHT_W-1:0]        out_draw_from_layer;
  logic signed [HEIGHT_W-1:0] out_draw_to_layer;
  logic signed [HEIGHT_W-1:0] out_top_layer;

  z_order_layer_list_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sheet_id        (in_sheet_id),
    .in_target_height   (in_target_height),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_applied_height (out_applied_height),
    .out_refresh        (out_refresh),
    .out_map_from_layer (out_map_from_layer),
    .out_draw_from_layer(out_draw_from_layer),
    .out_draw_to_layer  (out_draw_to_layer),
    .out_top_layer      (out_top_layer)
  );

  // Model of the stack: order table, height per sheet and top height.
  logic [ID_W-1:0] stack_order [NUM_SHEETS];
  int              stack_height [NUM_SHEETS];
  int              stack_top;

  restack_req_t pending_reqs [$];
  redraw_t      expected_redraws [$];

  int src_idle_pct  = 0;
  int sink_stall_pct = 0;
  int errors        = 0;
  int accepted      = 0;
  int checked       = 0;
  int refreshes     = 0;
  int tallest       = -1;
  int cycles        = 0;

  initial begin
    for (int i = 0; i < NUM_SHEETS; i++) begin
      stack_order[i]  = '0;
      stack_height[i] = HIDDEN;
    end
    stack_top = HIDDEN;
  end

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles,
               expected_redraws.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Applies one request to the model and returns the redraw result it causes.
  function automatic redraw_t restack(input logic [ID_W-1:0] sheet,
                                      input logic signed [HEIGHT_W-1:0] target);
    redraw_t r;
    int      old;
    int      lim;
    int      h;
    int      map_from;
    int      draw_from;
    int      draw_to;
    bit      changed;
    old       = stack_height[sheet];
    lim       = (old >= 0) ? stack_top : stack_top + 1;
    h         = target;
    map_from  = 0;
    draw_from = 0;
    draw_to   = -1;
    changed   = 1'b0;
    if (h > lim) h = lim;
    if (h < HIDDEN) h = HIDDEN;
    if (old > h) begin
      changed = 1'b1;
      if (h >= 0) begin
        for (int k = old; k > h; k--) begin
          stack_order[k] = stack_order[k-1];
          stack_height[stack_order[k]] = k;
        end
        stack_order[h]      = sheet;
        stack_height[sheet] = h;
        map_from  = h + 1;
        draw_from = h + 1;
        draw_to   = old;
      end else begin
        for (int k = old; k < stack_top; k++) begin
          stack_order[k] = stack_order[k+1];
          stack_height[stack_order[k]] = k;
        end
        stack_height[sheet] = HIDDEN;
        stack_top--;
        draw_to = old - 1;
      end
    end else if (old < h) begin
      changed = 1'b1;
      if (old >= 0) begin
        for (int k = old; k < h; k++) begin
          stack_order[k] = stack_order[k+1];
          stack_height[stack_order[k]] = k;
        end
      end else begin
        // A hidden sheet slides in: everything from the target height upward moves up.
        for (int k = stack_top; k >= h; k--) begin
          stack_order[k+1] = stack_order[k];
          stack_height[stack_order[k+1]] = k + 1;
        end
        stack_top++;
      end
      stack_order[h]      = sheet;
      stack_height[sheet] = h;
      map_from  = h;
      draw_from = h;
      draw_to   = h;
    end
    r.applied   = h[HEIGHT_W-1:0];
    r.refresh   = changed;
    r.map_from  = map_from[HEIGHT_W-1:0];
    r.draw_from = draw_from[HEIGHT_W-1:0];
    r.draw_to   = draw_to[HEIGHT_W-1:0];
    r.top       = stack_top[HEIGHT_W-1:0];
    return r;
  endfunction

  // Driver: valid is held until the transfer; a new item is loaded only after one or while valid is low.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        expected_redraws.push_back(restack(in_sheet_id, in_target_height));
        accepted++;
        if (stack_top > tallest) tallest = stack_top;
      end
      if (pending_reqs.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        restack_req_t req;
        req = pending_reqs.pop_front();
        in_valid         <= 1'b1;
        in_sheet_id      <= req.sheet;
        in_target_height <= req.target;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic report(input string field, input int want, input int got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    errors++;
  endtask

  // Monitor: compares each result transfer with the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < sink_stall_pct);
      if (out_valid && !out_stall) begin
        if (expected_redraws.size() == 0) begin
          $display("%0t: result transfer with nothing expected, top %0d", $time,
                   out_top_layer);
          errors++;
        end else begin
          redraw_t want;
          want = expected_redraws.pop_front();
          checked++;
          if (want.refresh) refreshes++;
          if (out_applied_height !== want.applied)
            report("applied_height", want.applied, $signed(out_applied_height));
          if (out_refresh !== want.refresh)
            report("refresh", want.refresh, out_refresh);
          if (out_map_from_layer !== want.map_from)
            report("map_from_layer", want.map_from, out_map_from_layer);
          if (out_draw_from_layer !== want.draw_from)
            report("draw_from_layer", want.draw_from, out_draw_from_layer);
          if (out_draw_to_layer !== want.draw_to)
            report("draw_to_layer", want.draw_to, $signed(out_draw_to_layer));
          if (out_top_layer !== want.top)
            report("top_layer", want.top, $signed(out_top_layer));
        end
      end
    end
  end

  task automatic queue_req(input int sheet, input int target);
    restack_req_t req;
    req.sheet  = sheet[ID_W-1:0];
    req.target = target[HEIGHT_W-1:0];
    pending_reqs.push_back(req);
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_valid || expected_redraws.size() != 0)
      @(negedge clk);
  endtask

  // Random requests, chosen from the model's current stack so that most are meaningful.
  task automatic random_phase(input int count);
    int sheet;
    int target;
    int pick;
    int hide_pct;
    for (int n = 0; n < count; n++) begin
      while (pending_reqs.size() >= 2) @(negedge clk);
      sheet    = $urandom_range(NUM_SHEETS - 1);
      pick     = $urandom_range(99);
      hide_pct = (stack_top < 200) ? 12 : 40;
      if (pick < 5) begin
        target = $urandom_range(511);
        if (target > 255) target = target - 512;
      end else if (pick < 9) begin
        target = stack_height[sheet];
      end else if (pick < 9 + hide_pct) begin
        target = HIDDEN;
      end else begin
        target = $urandom_range(stack_top + 1, 0);
      end
      queue_req(sheet, target);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty stack, clamping at both ends, every kind of move.
    queue_req(5, -1);      // hiding a hidden sheet changes nothing
    queue_req(5, 3);       // insert clamps to top plus one
    queue_req(0, 255);     // insert clamps to the top of the stack
    queue_req(255, 0);     // insert at the bottom pushes all up
    queue_req(7, 1);       // insert in the middle
    queue_req(255, 255);   // raise clamps to the current top
    queue_req(255, 0);     // lower to the bottom
    queue_req(0, 1);       // lower by two steps
    queue_req(7, 3);       // raise to the top
    queue_req(7, 3);       // same height again: no change
    queue_req(5, -1);      // hide from the middle
    queue_req(5, -256);    // most negative target on a hidden sheet
    queue_req(128, -256);  // most negative target on a hidden sheet
    queue_req(128, 255);   // insert at the top
    queue_req(64, 0);
    queue_req(255, -2);    // below minus one clamps to hide
    queue_req(128, -1);    // hide the top sheet
    queue_req(7, -1);
    queue_req(64, -1);
    queue_req(0, -1);      // empties the stack
    queue_req(0, -1);
    queue_req(170, 170);
    queue_req(85, 0);
    wait_idle();

    random_phase(PHASE_ITEMS);
    wait_idle();

    src_idle_pct = 55;
    random_phase(PHASE_ITEMS);
    wait_idle();

    // The sender holds off until every result is in before the next phase.
    src_idle_pct   = 0;
    sink_stall_pct = 55;
    random_phase(PHASE_ITEMS);
    wait_idle();

    src_idle_pct   = 7;
    sink_stall_pct = 7;
    random_phase(PHASE_ITEMS);
    wait_idle();

    sink_stall_pct = 0;
    repeat (SETTLE) @(posedge clk);

    $display("Checked %0d results from %0d requests, %0d with a redraw.", checked,
             accepted, refreshes);
    $display("Stack reached height %0d under four idle and stall mixes.", tallest);
    if (errors == 0 && expected_redraws.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expected_redraws.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/zoll_pkg.sv
hw/rtl/zoll_ram.sv
hw/rtl/z_order_layer_list_top.sv
tb/sv/testbench.sv
